// ===== design/ids_pkg.sv =====
// Shared types and constants of the isotropic direction sampler.
// Used by the sampler top level and by its port checker; no dependencies.
`default_nettype none

package ids_pkg;

	// Width of every sample and direction field on the ports.
	localparam int FIELD_W = 24;

	// Square root result bits; one pipeline stage resolves one bit.
	localparam int ROOT_W = 32;

	// Offset, square, sum, radicand, root stages, product, output.
	localparam int LATENCY = 6 + ROOT_W;

	typedef struct packed {
		logic [FIELD_W-1:0] first_uniform;
		logic [FIELD_W-1:0] second_uniform;
	} sample_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] dir_x;
		logic signed [FIELD_W-1:0] dir_y;
		logic signed [FIELD_W-1:0] dir_z;
	} direction_t;

endpackage

`default_nettype wire

// ===== design/isotropic_direction_sampler.sv =====
// Pipelined isotropic direction sampler: two uniform samples in, one unit direction out.
// Depends on ids_pkg for the request and result types and the stage constants.
`default_nettype none

// Usage
//   Request channel: drive sample and raise start; the request is taken at
//   every rising edge with start high and busy low. busy stays low, so a new
//   pair can enter on every cycle and throughput is one request per cycle.
//   Result channel: done is high for exactly one cycle with the direction on
//   result (signed, FRACTION_BITS fraction bits, saturated to [-1, +1]).
//   A pair that falls outside the disk gives no done pulse at all, so results
//   keep the order of the accepted pairs that survive the disk test.
// Pipeline
//   The direction on result and done are registered together in the output
//   stage. The depth is set by the square root, which resolves one root bit
//   per stage over 32 stages, plus six stages for offsets, squares, sum, the
//   disk test with radicand and z, the x/y products and the output rounding.
// Reset
//   arst_n low clears every stage valid bit at once; requests in flight are
//   dropped and no done pulse follows them. The receiver cannot stall, so the
//   pipeline advances on every clock.
module isotropic_direction_sampler #(
	parameter int SAMPLE_BITS   = 24,
	parameter int FRACTION_BITS = 22
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire ids_pkg::sample_t     sample,
	output logic                      done,
	output ids_pkg::direction_t       result
);

	localparam int S      = SAMPLE_BITS;
	localparam int F      = FRACTION_BITS;
	localparam int FW     = ids_pkg::FIELD_W;
	localparam int ROOT_W = ids_pkg::ROOT_W;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 4;
	localparam int G      = ROOT_W - S;
	localparam int ZSH    = 2 * S - 3 - F;
	localparam int SH     = S + 29 - F;
	localparam int PW     = S + ROOT_W;

	localparam logic [2*S-1:0]      QUARTER = {2'b01, {(2*S-2){1'b0}}};
	localparam logic signed [F+2:0] ONE     = {3'b001, {F{1'b0}}};
	localparam logic [PW:0]         RND_XY  = (PW+1)'(1) << (SH - 1);

	typedef struct packed {
		logic [S-1:0]  mag_a;
		logic [S-1:0]  mag_b;
		logic          neg_a;
		logic          neg_b;
		logic [FW-1:0] dir_z;
	} side_t;

	// |u - 2^(S-1)| in S bits
	function automatic logic [S-1:0] centred_mag(input logic [S-1:0] u);
		logic [S-1:0] half;
		half = {1'b1, {(S-1){1'b0}}};
		return u[S-1] ? {1'b0, u[S-2:0]} : (half - u);
	endfunction

	// saturate to [-1, +1] and fit to the port field
	function automatic logic [FW-1:0] fit_field(input logic signed [F+2:0] v);
		logic signed [F+2:0] c;
		if (v > ONE)
			c = ONE;
		else if (v < -ONE)
			c = -ONE;
		else
			c = v;
		return FW'(c);
	endfunction

	// round |c|*q to F fraction bits, ties away from zero, then apply sign
	function automatic logic [FW-1:0] round_component(input logic [PW-1:0] prod,
		input logic neg);
		logic [PW:0]         sum;
		logic [F+1:0]        mag;
		logic signed [F+2:0] v;
		sum = {1'b0, prod} + RND_XY;
		mag = sum[SH +: F+2];
		v = $signed({1'b0, mag});
		if (neg)
			v = -v;
		return fit_field(v);
	endfunction

	assign busy = 1'b0;

	// ---------------- stage 1: centred offsets ----------------
	logic [S-1:0] u1, u2;

	if (S <= FW) begin : g_narrow
		assign u1 = sample.first_uniform[S-1:0];
		assign u2 = sample.second_uniform[S-1:0];
	end else begin : g_wide
		assign u1 = {{(S-FW){1'b0}}, sample.first_uniform};
		assign u2 = {{(S-FW){1'b0}}, sample.second_uniform};
	end

	logic         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [S-1:0] mag_a_s1, mag_b_s1, mag_a_s2, mag_b_s2, mag_a_s3, mag_b_s3;
	logic         neg_a_s1, neg_b_s1, neg_a_s2, neg_b_s2, neg_a_s3, neg_b_s3;
	logic [2*S-1:0] sq_a_s2, sq_b_s2;
	logic [2*S-1:0] r2_s3;
	logic [RAD_W-1:0] rad_s4;
	side_t        side_s4;
	logic [PW-1:0] prod_x_s5, prod_y_s5;
	logic         neg_a_s5, neg_b_s5;
	logic [FW-1:0] dir_z_s5;
	ids_pkg::direction_t res_s6;

	// ---------------- stage 4 helpers: disk test and z ----------------
	logic                keep;
	logic [F+1:0]        zs;
	logic signed [F+2:0] z_val;

	assign keep = vld_s3 && (r2_s3 <= QUARTER);

	if (ZSH > 0) begin : g_zs_round
		logic [2*S:0] zsum;
		assign zsum = {1'b0, r2_s3} + ((2*S+1)'(1) << (ZSH - 1));
		assign zs   = zsum[ZSH +: F+2];
	end else if (ZSH == 0) begin : g_zs_exact
		assign zs = r2_s3[F+1:0];
	end else begin : g_zs_up
		assign zs = {r2_s3[F+1+ZSH:0], {(-ZSH){1'b0}}};
	end

	assign z_val = $signed({1'b0, zs}) - ONE;

	// ---------------- square root stages ----------------
	logic              sq_vld_s  [ROOT_W];
	logic [REM_W-1:0]  sq_rem_s  [ROOT_W];
	logic [ROOT_W-1:0] sq_root_s [ROOT_W];
	logic [RAD_W-1:0]  sq_rad_s  [ROOT_W];
	side_t             sq_side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic              vld_in;
		logic [REM_W-1:0]  rem_in, rem_try, trial;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		side_t             side_in;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s4;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_s4;
			assign side_in = side_s4;
		end else begin : g_next
			assign vld_in  = sq_vld_s[k-1];
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign rad_in  = sq_rad_s[k-1];
			assign side_in = sq_side_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_try = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial   = REM_W'({root_in, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k] <= 1'b0;
			end else begin
				sq_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rem_try >= trial) begin
				sq_rem_s[k]  <= rem_try - trial;
				sq_root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
			end else begin
				sq_rem_s[k]  <= rem_try;
				sq_root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
			end
			sq_rad_s[k]  <= rad_in << 2;
			sq_side_s[k] <= side_in;
		end
	end

	// ---------------- control: valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= keep;
			vld_s5 <= sq_vld_s[ROOT_W-1];
			vld_s6 <= vld_s5;
		end
	end

	// ---------------- payload ----------------
	always_ff @(posedge clk) begin
		mag_a_s1 <= centred_mag(u1);
		mag_b_s1 <= centred_mag(u2);
		neg_a_s1 <= ~u1[S-1];
		neg_b_s1 <= ~u2[S-1];

		sq_a_s2  <= mag_a_s1 * mag_a_s1;
		sq_b_s2  <= mag_b_s1 * mag_b_s1;
		mag_a_s2 <= mag_a_s1;
		mag_b_s2 <= mag_b_s1;
		neg_a_s2 <= neg_a_s1;
		neg_b_s2 <= neg_b_s1;

		r2_s3    <= sq_a_s2 + sq_b_s2;
		mag_a_s3 <= mag_a_s2;
		mag_b_s3 <= mag_b_s2;
		neg_a_s3 <= neg_a_s2;
		neg_b_s3 <= neg_b_s2;

		rad_s4        <= RAD_W'(QUARTER - r2_s3) << (2 * G);
		side_s4.mag_a <= mag_a_s3;
		side_s4.mag_b <= mag_b_s3;
		side_s4.neg_a <= neg_a_s3;
		side_s4.neg_b <= neg_b_s3;
		side_s4.dir_z <= fit_field(z_val);

		prod_x_s5 <= {{ROOT_W{1'b0}}, sq_side_s[ROOT_W-1].mag_a}
			* {{S{1'b0}}, sq_root_s[ROOT_W-1]};
		prod_y_s5 <= {{ROOT_W{1'b0}}, sq_side_s[ROOT_W-1].mag_b}
			* {{S{1'b0}}, sq_root_s[ROOT_W-1]};
		neg_a_s5  <= sq_side_s[ROOT_W-1].neg_a;
		neg_b_s5  <= sq_side_s[ROOT_W-1].neg_b;
		dir_z_s5  <= sq_side_s[ROOT_W-1].dir_z;

		res_s6.dir_x <= round_component(prod_x_s5, neg_a_s5);
		res_s6.dir_y <= round_component(prod_y_s5, neg_b_s5);
		res_s6.dir_z <= dir_z_s5;
	end

	assign done   = vld_s6;
	assign result = res_s6;

endmodule

`default_nettype wire

// ===== design/ids_checker.sv =====
// Port-level checker for the isotropic direction sampler, bound to its top level.
// Depends on ids_pkg for the request/result types and the pipeline latency.
`default_nettype none

module ids_checker #(
	parameter int SAMPLE_BITS   = 24,
	parameter int FRACTION_BITS = 22
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire ids_pkg::sample_t    sample,
	input wire logic                done,
	input wire ids_pkg::direction_t result
);

	localparam int LAT = ids_pkg::LATENCY;
	localparam int FW  = ids_pkg::FIELD_W;

	localparam logic [FW-1:0] NEG_ONE = FW'(-(64'sd1 <<< FRACTION_BITS));

	logic accept;
	assign accept = start && !busy;

	// every result traces back to an accepted request
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("done without a request one latency earlier");

	// both samples zero lie outside the disk: drop
	a_corner_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample.first_uniform == '0 && sample.second_uniform == '0)
		|-> ##LAT !done)
		else $error("corner pair was not rejected");

	if (SAMPLE_BITS <= FW) begin : g_centre
		localparam logic [FW-1:0] HALF = FW'(64'd1 << (SAMPLE_BITS - 1));

		// the disk centre maps to the south pole
		a_centre_pole: assert property (@(posedge clk) disable iff (!arst_n)
			(accept && sample.first_uniform == HALF && sample.second_uniform == HALF)
			|-> ##LAT (done && result.dir_x == '0 && result.dir_y == '0
				&& result.dir_z == NEG_ONE))
			else $error("centre pair did not give the south pole");
	end

	if (FRACTION_BITS + 2 <= FW) begin : g_range
		localparam logic signed [FW-1:0] ONE = FW'(64'sd1 <<< FRACTION_BITS);

		a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
			done |-> (result.dir_z <= ONE && result.dir_z >= -ONE))
			else $error("dir_z outside [-1, +1]");
	end

endmodule

bind isotropic_direction_sampler ids_checker #(
	.SAMPLE_BITS  (SAMPLE_BITS),
	.FRACTION_BITS(FRACTION_BITS)
) u_ids_checker (.*);

`default_nettype wire
